// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swm_pkg: shared types and constants of the sliding-window median filter
// Sample width, default window depth, the sorter state encoding and the
// command handed from the top level to the sorter at the start of an item.
// ============================================================================
package swm_pkg;

  localparam int SAMPLE_W       = 15;
  localparam int TDATA_W        = 16;
  localparam int WINDOW_DEFAULT = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Sorter sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_DIR,
    ST_BUBBLE,
    ST_LOW,
    ST_HIGH
  } swm_state_t;

  // Everything the sorter needs to know about a newly accepted beat.
  typedef struct packed {
    logic    full;
    sample_t new_val;
    sample_t old_val;
  } swm_cmd_t;

endpackage : swm_pkg
`default_nettype wire

// ===== rtl/core/swm_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swm_ring: circular sample store in arrival order
// Holds the most recent samples, the fill count and the oldest slot, and
// presents the sample that the next write into a full window will evict.
// ============================================================================
module swm_ring #(
  parameter int W  = swm_pkg::WINDOW_DEFAULT,
  parameter int IW = (W > 1) ? $clog2(W) : 1,
  parameter int CW = $clog2(W + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      wr_en,
  input  wire swm_pkg::sample_t    wr_data,
  output logic                     full,
  output logic [CW-1:0]            fill,
  output swm_pkg::sample_t         old_val
);
  import swm_pkg::*;

  sample_t         store_r [W];
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [IW-1:0]   oldest_r, oldest_nxt;
  logic [IW-1:0]   wr_idx;

  assign full    = (fill_r == CW'(W));
  assign fill    = fill_r;
  assign old_val = store_r[oldest_r];

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    wr_idx     = full ? oldest_r : fill_r[IW-1:0];
    if (wr_en) begin
      if (!full) begin
        fill_nxt = fill_r + CW'(1);
      end else if (oldest_r == IW'(W - 1)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= wr_data;
    end
  end

endmodule : swm_ring
`default_nettype wire

// ===== rtl/core/swm_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swm_sorter: sorted copy of the window and the shared compare/add unit
// A small sequencer finds the evicted value, moves the new value to its
// place one step per cycle, then reads and averages the two middle entries.
// ============================================================================
module swm_sorter #(
  parameter int W  = swm_pkg::WINDOW_DEFAULT,
  parameter int IW = (W > 1) ? $clog2(W) : 1,
  parameter int CW = $clog2(W + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire swm_pkg::swm_cmd_t   cmd,
  input  wire [CW-1:0]             fill,
  input  wire                      out_free,
  output logic                     idle,
  output logic                     done,
  output swm_pkg::sample_t         median
);
  import swm_pkg::*;

  swm_state_t      state_r, state_nxt;
  sample_t         srt_r [W];
  sample_t         v_r, v_nxt;
  sample_t         old_r, old_nxt;
  sample_t         a_r, a_nxt;
  logic [IW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic            up_r, up_nxt;

  logic [IW-1:0]   rd_idx;
  sample_t         rd_data;
  sample_t         cmp_b;
  logic            a_lt_b, a_eq_b;
  logic [SAMPLE_W:0] sum;
  logic            k_last, move;
  logic            we;
  sample_t         wdata;

  // Single read port into the sorted array; out-of-range reads return zero.
  always_comb begin
    case (state_r)
      ST_FIND, ST_DIR: rd_idx = k_r;
      ST_BUBBLE:       rd_idx = up_r ? (k_r + IW'(1)) : (k_r - IW'(1));
      ST_LOW:          rd_idx = IW'((n_r - CW'(1)) >> 1);
      ST_HIGH:         rd_idx = IW'(n_r >> 1);
      default:         rd_idx = k_r;
    endcase
  end

  assign rd_data = ({1'b0, rd_idx} < (IW + 1)'(W)) ? srt_r[rd_idx] : '0;

  // Shared compare and add unit.
  assign cmp_b  = (state_r == ST_FIND) ? old_r : v_r;
  assign a_lt_b = (rd_data < cmp_b);
  assign a_eq_b = (rd_data == cmp_b);
  assign sum    = {1'b0, a_r} + {1'b0, rd_data};

  assign k_last = (k_r == IW'(n_r - CW'(1)));
  assign move   = up_r ? (!k_last && a_lt_b) : ((k_r != '0) && !a_lt_b && !a_eq_b);

  assign idle   = (state_r == ST_IDLE);
  assign median = sum[SAMPLE_W:1];

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    old_nxt   = old_r;
    a_nxt     = a_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    up_nxt    = up_r;
    we        = 1'b0;
    wdata     = v_r;
    done      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          v_nxt   = cmd.new_val;
          old_nxt = cmd.old_val;
          up_nxt  = 1'b0;
          if (cmd.full) begin
            n_nxt     = CW'(W);
            k_nxt     = '0;
            state_nxt = ST_FIND;
          end else begin
            // Growing window: the new value enters at the top and sinks.
            n_nxt     = fill + CW'(1);
            k_nxt     = fill[IW-1:0];
            state_nxt = ST_BUBBLE;
          end
        end
      end
      ST_FIND: begin
        if (a_eq_b || k_last) begin
          state_nxt = ST_DIR;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_DIR: begin
        // The evicted value sits at k; a larger new value rises.
        up_nxt    = a_lt_b;
        state_nxt = ST_BUBBLE;
      end
      ST_BUBBLE: begin
        we = 1'b1;
        if (move) begin
          wdata = rd_data;
          k_nxt = up_r ? (k_r + IW'(1)) : (k_r - IW'(1));
        end else begin
          wdata     = v_r;
          state_nxt = ST_LOW;
        end
      end
      ST_LOW: begin
        a_nxt     = rd_data;
        state_nxt = ST_HIGH;
      end
      ST_HIGH: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    old_r <= old_nxt;
    a_r   <= a_nxt;
    k_r   <= k_nxt;
    n_r   <= n_nxt;
    up_r  <= up_nxt;
    if (we) begin
      srt_r[k_r] <= wdata;
    end
  end

endmodule : swm_sorter
`default_nettype wire

// ===== rtl/core/sliding_window_median_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Between the input beat and the result beat the sorter searches a full
// window for the evicted value, then inserts the new one step per cycle.
// Throughput: one beat per item; in_tready rises at the same edge that
// loads the result register, so no beat is taken while an item is in work.
// The sorter also holds its result while the output register is full.
// Reset: rst_n is synchronous, active low; the window is empty afterwards.
// ============================================================================
// sliding_window_median_top: running median over the last WINDOW samples
// A ring store keeps samples in arrival order, a sorter keeps a sorted copy
// and reports the median; an output register decouples the result stream.
// ============================================================================
module sliding_window_median_top #(
  parameter int WINDOW = swm_pkg::WINDOW_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [swm_pkg::TDATA_W-1:0]   in_tdata,   // [14:0] sample, [15] zero
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [swm_pkg::TDATA_W-1:0]  out_tdata   // [14:0] median_value, [15] zero
);
  import swm_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  logic          in_beat;
  logic          ring_full;
  logic [CW-1:0] ring_fill;
  sample_t       ring_old;
  swm_cmd_t      cmd;
  logic          srt_idle;
  logic          srt_done;
  sample_t       srt_median;
  logic          out_free;

  logic          out_valid_r, out_valid_nxt;
  sample_t       out_data_r, out_data_nxt;

  // A beat is accepted only when the sorter has finished the previous item;
  // a finished result may still wait in the output register meanwhile.
  assign in_tready = srt_idle;
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cmd.full    = ring_full;
  assign cmd.new_val = in_tdata[SAMPLE_W-1:0];
  assign cmd.old_val = ring_old;

  // The ring is written on the accept edge; the sorter latches the evicted
  // value and the pre-write fill count in the same edge.
  swm_ring #(
    .W  (WINDOW),
    .IW (IW),
    .CW (CW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_beat),
    .wr_data (in_tdata[SAMPLE_W-1:0]),
    .full    (ring_full),
    .fill    (ring_fill),
    .old_val (ring_old)
  );

  swm_sorter #(
    .W  (WINDOW),
    .IW (IW),
    .CW (CW)
  ) u_sorter (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_beat),
    .cmd      (cmd),
    .fill     (ring_fill),
    .out_free (out_free),
    .idle     (srt_idle),
    .done     (srt_done),
    .median   (srt_median)
  );

  // Output register: loaded when the sorter finishes, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (srt_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = srt_median;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - SAMPLE_W){1'b0}}, out_data_r};

  // After a beat is taken, the sorter is not ready again in the next cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A finished result never overwrites one that has not been delivered.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    srt_done |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // The fill count stays within the window depth.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    ring_fill <= CW'(WINDOW))
    else $error("fill count beyond window depth");

  // After finishing, the sorter returns to idle and raises the input ready.
  a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    srt_done |=> in_tready)
    else $error("sorter not idle after finishing");

endmodule : sliding_window_median_top
`default_nettype wire

// ===== dv/swm_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// swm_checker: result checker of the sliding-window median filter
// Watches both stream channels, keeps its own copy of the sample window,
// predicts the median for every accepted input beat and compares it with
// the result beats in order.
// ============================================================================
module swm_checker #(
  parameter int WINDOW = swm_pkg::WINDOW_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  input  wire                         in_tready,
  input  wire [swm_pkg::TDATA_W-1:0]  in_tdata,   // [14:0] sample, [15] zero
  input  wire                         out_tvalid,
  input  wire                         out_tready,
  input  wire [swm_pkg::TDATA_W-1:0]  out_tdata,  // [14:0] median_value, [15] zero
  output int                          fail_count,
  output int                          pending_count,
  output int                          medians_checked
);
  import swm_pkg::*;

  sample_t     win_store [WINDOW];
  int unsigned held_count;
  int unsigned oldest_idx;
  sample_t     expected_medians [$];

  // Median of the held samples, by insertion sort of a local copy.
  function automatic sample_t window_median();
    sample_t           sorted [WINDOW];
    sample_t           v;
    int                j;
    logic [SAMPLE_W:0] pair_sum;
    for (int i = 0; i < held_count; i++) begin
      v = win_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (held_count % 2 == 0) begin
      pair_sum = sorted[held_count/2 - 1] + sorted[held_count/2];
      return pair_sum[SAMPLE_W:1];
    end
    return sorted[held_count/2];
  endfunction

  always @(posedge clk) begin : track
    sample_t s;
    sample_t want;
    if (!rst_n) begin
      held_count = 0;
      oldest_idx = 0;
      expected_medians.delete();
      fail_count      <= 0;
      medians_checked <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_medians.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected result beat, actual 0x%04h", $time, out_tdata);
        end else begin
          want = expected_medians.pop_front();
          medians_checked <= medians_checked + 1;
          if (out_tdata !== {1'b0, want}) begin
            fail_count <= fail_count + 1;
            $display("%0t: median mismatch, expected 0x%04h actual 0x%04h",
                     $time, {1'b0, want}, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        s = in_tdata[SAMPLE_W-1:0];
        if (held_count < WINDOW) begin
          win_store[held_count] = s;
          held_count++;
        end else begin
          win_store[oldest_idx] = s;
          oldest_idx = (oldest_idx == WINDOW - 1) ? 0 : oldest_idx + 1;
        end
        expected_medians = {expected_medians, window_median()};
      end
    end
    pending_count <= expected_medians.size();
  end

endmodule : swm_checker

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the sliding-window median filter
// Drives sample beats into the filter with random idling on both stream
// sides, a long output stall, a steady-flow stretch and pauses for the
// results; the checker beside the filter predicts and compares every median.
// ============================================================================
module tb_top;
  import swm_pkg::*;

  localparam int WINDOW          = WINDOW_DEFAULT;
  // Worst-case latency of one beat once the window is full.
  localparam int MAX_LATENCY     = 2 * WINDOW + 4;
  // The limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DIRECTED_ITEMS  = 21;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tready = 1'b0;
  wire                in_tready;
  wire                out_tvalid;
  wire  [TDATA_W-1:0] out_tdata;

  int          fail_count;
  int          pending_count;
  int          medians_checked;
  int unsigned cycle_count  = 0;
  int          samples_sent = 0;
  // When set, neither side of the filter idles.
  bit          steady_flow  = 1'b0;
  // Each toggle asks the receiver for one long hold-off.
  bit          hold_off_req = 1'b0;
  sample_t     last_sample  = '0;

  sliding_window_median_top #(.WINDOW(WINDOW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  swm_checker #(.WINDOW(WINDOW)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .medians_checked (medians_checked)
  );

  // Free-running clock with a 4 ns period.
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run here as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still expected",
             $time, cycle_count, pending_count);
    $display("== FAIL ==");
    $finish;
  end

  // Result side. The ready line idles about a third of the cycles, never
  // during the steady-flow stretch, and drops for a long hold-off each time
  // the stimulus toggles the request. The hold-off is counted here, so the
  // sender keeps offering beats while the filter backs up.
  initial begin : receiver
    bit seen_req;
    int hold_left;
    seen_req  = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req != seen_req) begin
        seen_req  = hold_off_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (steady_flow) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // Directed samples: extremes and alternating bit patterns while the window
  // grows through every count from one to full, then two runs of one value,
  // together longer than the window, that carry the oldest slot past its wrap.
  function automatic sample_t directed_sample(input int idx);
    case (idx)
      0:       return 15'h0000;
      1:       return 15'h7FFF;
      2:       return 15'h7FFF;
      3:       return 15'h0000;
      4:       return 15'h5555;
      5:       return 15'h2AAA;
      6:       return 15'h0001;
      7:       return 15'h7FFE;
      8:       return 15'h4000;
      9:       return 15'h3FFF;
      10, 11, 12, 13, 14: return 15'h7FFF;
      default: return 15'h0000;
    endcase
  endfunction

  // Random sample: uniform values, small values that give many ties,
  // the extremes, and slow drifts around the previous sample.
  function automatic sample_t pick_sample(input sample_t prev);
    int kind;
    int val;
    kind = $urandom_range(99);
    if (kind < 40) begin
      val = $urandom_range(32767);
    end else if (kind < 60) begin
      val = $urandom_range(7);
    end else if (kind < 75) begin
      case ($urandom_range(3))
        0:       val = 0;
        1:       val = 1;
        2:       val = 32766;
        default: val = 32767;
      endcase
    end else begin
      val = int'(prev) + $urandom_range(128) - 64;
      if (val < 0) val = 0;
      if (val > 32767) val = 32767;
    end
    return sample_t'(val);
  endfunction

  // Offers one sample beat and waits for it to be taken. The valid line
  // stays high into the next beat unless an idle gap follows; during a gap
  // the data lines carry junk.
  task automatic send_sample(input sample_t s);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, s};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    last_sample = s;
    if (!steady_flow && $urandom_range(99) < 32) begin
      // Mostly short gaps; now and then one long enough to land on any
      // phase of a full-window sort.
      gap = ($urandom_range(7) == 0) ? $urandom_range(30, 5) : $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      in_tdata  <= TDATA_W'($urandom_range(16'hFFFF));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(pick_sample(last_sample));
    end
  endtask

  // Stops offering and waits until every expected median has arrived. The
  // first edge lets the checker count a beat taken at the edge just passed.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    // Synchronous reset, held from the start, then released for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      send_sample(directed_sample(i));
    end

    // The sender pauses here until the filter has returned everything.
    wait_for_results();

    send_random(300);

    // The receiver holds off for a long stretch while beats keep coming, so
    // the output register fills and the input side stalls.
    hold_off_req <= ~hold_off_req;
    send_random(60);

    // Steady flow: neither side idles, each beat is offered as soon as it can be taken.
    steady_flow <= 1'b1;
    @(posedge clk);
    send_random(200);
    steady_flow <= 1'b0;

    wait_for_results();
    send_random(370);

    // Drain, then let the filter run a little past its worst latency so
    // that any stray result beat is caught.
    wait_for_results();
    repeat (MAX_LATENCY + 8) @(posedge clk);

    $display("Sent %0d samples and checked %0d medians in %0d cycles.",
             samples_sent, medians_checked, cycle_count);
    $display("Covered window growth, wrap-around, long output stall, idle and steady flow.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb_top
